@@ design/fmt_pkg.sv @@
`timescale 1ns / 1ps

package fmt_pkg;

   localparam int unsigned FMT_LIMIT = 9999;
   localparam logic [7:0] FMT_ZERO_CHAR  = 8'd48;
   localparam logic [7:0] FMT_SPACE_CHAR = 8'h20;
   localparam logic [7:0] FMT_STAR_CHAR  = 8'h2A;
   localparam logic [7:0] FMT_POINT_CHAR = 8'h2E;
   localparam logic [7:0] FMT_C_CHAR     = 8'h63;
   localparam logic [7:0] FMT_M_CHAR     = 8'h6D;

   localparam logic       FMT_MODE_INT  = 1'b0;
   localparam logic       FMT_MODE_DIST = 1'b1;

   localparam logic [2:0] FMT_LAST_INT  = 3'd4;
   localparam logic [2:0] FMT_LAST_DIST = 3'd7;

   // multiples of the digit weights 1000, 100 and 10
   localparam logic [13:0] FMT_MULT [0:2][0:9] = '{
      '{14'd0, 14'd1000, 14'd2000, 14'd3000, 14'd4000,
        14'd5000, 14'd6000, 14'd7000, 14'd8000, 14'd9000},
      '{14'd0, 14'd100, 14'd200, 14'd300, 14'd400,
        14'd500, 14'd600, 14'd700, 14'd800, 14'd900},
      '{14'd0, 14'd10, 14'd20, 14'd30, 14'd40,
        14'd50, 14'd60, 14'd70, 14'd80, 14'd90}
   };

   typedef enum logic [1:0] {
      FMT_FRONT_IDLE,
      FMT_FRONT_CONV,
      FMT_FRONT_HOLD
   } fmt_front_state_type;

   typedef struct packed {
      logic             mode;
      logic             over;
      logic [3:0][3:0]  digit;   // digit[0] is the thousands digit
   } fmt_entry_type;

   typedef struct packed {
      logic          valid;
      fmt_entry_type entry;
   } fmt_push_type;

   function automatic logic [7:0] fmt_char(input fmt_entry_type e, input logic [2:0] pos);
      logic [7:0] ch;
      logic       shown;
      logic [3:0] dg;
      ch    = FMT_SPACE_CHAR;
      shown = 1'b0;
      dg    = 4'd0;
      if (e.mode == FMT_MODE_INT) begin
         dg = e.digit[pos[1:0]];
         for (int k = 0; k < 4; k++) begin
            if ((3'(k) <= pos) && (e.digit[k] != 4'd0)) begin
               shown = 1'b1;
            end
         end
         case (pos)
            3'd0, 3'd1, 3'd2, 3'd3: begin
               if (e.over) begin
                  ch = FMT_STAR_CHAR;
               end else if (shown || pos == 3'd3) begin
                  ch = {4'd0, dg} + FMT_ZERO_CHAR;
               end else begin
                  ch = FMT_SPACE_CHAR;
               end
            end
            default: ch = FMT_SPACE_CHAR;
         endcase
      end else begin
         case (pos)
            3'd0: begin
               dg = e.digit[0];
               ch = e.over ? FMT_STAR_CHAR : {4'd0, dg} + FMT_ZERO_CHAR;
            end
            3'd1: ch = FMT_POINT_CHAR;
            3'd2, 3'd3, 3'd4: begin
               dg = e.digit[2'(pos - 3'd1)];
               ch = e.over ? FMT_STAR_CHAR : {4'd0, dg} + FMT_ZERO_CHAR;
            end
            3'd5: ch = FMT_SPACE_CHAR;
            3'd6: ch = FMT_C_CHAR;
            3'd7: ch = FMT_M_CHAR;
            default: ch = FMT_SPACE_CHAR;
         endcase
      end
      return ch;
   endfunction

endpackage

@@ design/fixed_field_decimal_formatter_unit.sv @@
`timescale 1ns / 1ps

// A taken value passes the front's digit extraction, the queue and the back's field and
// output registers. Front is busy for three digit steps and while the queue is full;
// back emits one character per cycle, 5 per field in integer mode, 8 in distance mode.
// The result side cannot stall; fields come out back to back when the queue holds the next.
// Synchronous active-high reset clears control state and sets the format mode to integer.
module fixed_field_decimal_formatter_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_value,
   input  logic        csr_we,
   input  logic        csr_wdata,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_character,
   output logic        rsp_last_char
);
   import fmt_pkg::*;

   fmt_push_type  push;
   logic          push_ready;
   logic          fifo_valid;
   fmt_entry_type fifo_entry;
   logic          pop;

   fmt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_value  (req_value),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .push_ready (push_ready),
      .push       (push)
   );

   fmt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .pop_valid  (fifo_valid),
      .pop_entry  (fifo_entry),
      .pop        (pop)
   );

   fmt_back u_back (
      .clock         (clock),
      .reset         (reset),
      .fifo_valid    (fifo_valid),
      .fifo_entry    (fifo_entry),
      .pop           (pop),
      .rsp_strobe    (rsp_strobe),
      .rsp_character (rsp_character),
      .rsp_last_char (rsp_last_char)
   );

endmodule

@@ design/fmt_front.sv @@
`timescale 1ns / 1ps

module fmt_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [31:0]          req_value,
   input  logic                 csr_we,
   input  logic                 csr_wdata,
   input  logic                 push_ready,
   output fmt_pkg::fmt_push_type push
);
   import fmt_pkg::*;

   fmt_front_state_type state_ff, state_in;
   logic [1:0]    step_ff, step_in;
   logic [13:0]   rem_ff, rem_in;
   fmt_entry_type entry_ff, entry_in;
   logic          mode_ff, mode_in;
   logic [3:0]    q;
   logic [13:0]   rem_next;

   // one decimal digit per cycle: count the weight multiples not above the remainder
   always_comb begin
      q = 4'd0;
      for (int j = 1; j < 10; j++) begin
         if (rem_ff >= FMT_MULT[step_ff][j]) begin
            q = q + 4'd1;
         end
      end
      rem_next = rem_ff - FMT_MULT[step_ff][q];
   end

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      rem_in     = rem_ff;
      entry_in   = entry_ff;
      mode_in    = csr_we ? csr_wdata : mode_ff;
      push.valid = 1'b0;
      case (state_ff)
         FMT_FRONT_IDLE: begin
            if (start) begin
               state_in       = FMT_FRONT_CONV;
               step_in        = 2'd0;
               rem_in         = req_value[13:0];
               entry_in.mode  = mode_ff;
               entry_in.over  = req_value > 32'(FMT_LIMIT);
               entry_in.digit = '0;
            end
         end
         FMT_FRONT_CONV: begin
            entry_in.digit[step_ff] = q;
            rem_in  = rem_next;
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd2) begin
               entry_in.digit[3] = rem_next[3:0];
               push.valid        = 1'b1;
               state_in = push_ready ? FMT_FRONT_IDLE : FMT_FRONT_HOLD;
            end
         end
         FMT_FRONT_HOLD: begin
            push.valid = 1'b1;
            if (push_ready) begin
               state_in = FMT_FRONT_IDLE;
            end
         end
         default: state_in = FMT_FRONT_IDLE;
      endcase
      push.entry = entry_in;
   end

   assign busy = (state_ff != FMT_FRONT_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FMT_FRONT_IDLE;
         mode_ff  <= FMT_MODE_INT;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      rem_ff   <= rem_in;
      entry_ff <= entry_in;
   end

endmodule

@@ design/fmt_queue.sv @@
`timescale 1ns / 1ps

module fmt_queue #(
   parameter int DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  fmt_pkg::fmt_push_type push,
   output logic                  push_ready,
   output logic                  pop_valid,
   output fmt_pkg::fmt_entry_type pop_entry,
   input  logic                  pop
);
   import fmt_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   fmt_entry_type mem_ff [0:DEPTH-1];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = mem_ff[rd_ptr_ff];
   assign do_push    = push.valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

@@ design/fmt_back.sv @@
`timescale 1ns / 1ps

module fmt_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fifo_valid,
   input  fmt_pkg::fmt_entry_type fifo_entry,
   output logic                   pop,
   output logic                   rsp_strobe,
   output logic [7:0]             rsp_character,
   output logic                   rsp_last_char
);
   import fmt_pkg::*;

   logic          active_ff, active_in;
   logic [2:0]    pos_ff, pos_in;
   fmt_entry_type cur_ff, cur_in;
   logic          strobe_ff, strobe_in;
   logic [7:0]    char_ff, char_in;
   logic          last_ff, last_in;
   logic          is_last;

   assign is_last = (cur_ff.mode == FMT_MODE_INT) ? (pos_ff == FMT_LAST_INT)
                                                  : (pos_ff == FMT_LAST_DIST);
   // next field starts right after the last character, no gap, if the queue holds one
   assign pop = fifo_valid && (!active_ff || is_last);

   always_comb begin
      active_in = active_ff;
      pos_in    = pos_ff;
      cur_in    = cur_ff;
      if (pop) begin
         active_in = 1'b1;
         pos_in    = 3'd0;
         cur_in    = fifo_entry;
      end else if (active_ff) begin
         pos_in = pos_ff + 3'd1;
         if (is_last) begin
            active_in = 1'b0;
         end
      end
      strobe_in = active_ff;
      char_in   = fmt_char(cur_ff, pos_ff);
      last_in   = active_ff && is_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      cur_ff  <= cur_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_character = char_ff;
   assign rsp_last_char = last_ff;

endmodule
